FILE: rtl/core/crlsc_pkg.sv
// Shared types, constants and helper functions of the coefficient run-length symbol coder.
package crlsc_pkg;

    localparam int COMPONENTS_DEF  = 3;
    localparam int COEF_WIDTH_DEF  = 11;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int POS_W   = 6;
    localparam int COMP_W  = 2;
    localparam int VAL_W   = 12;
    localparam int AMP_W   = 11;
    localparam int SIZE_W  = 4;
    localparam int SYM_W   = 8;
    localparam int RUN_W   = 4;
    localparam int PEND_W  = 2;

    localparam int AMP_LIMIT = 2047;
    localparam int PRED_MAX  = 1023;
    localparam int PRED_MIN  = -1024;

    localparam logic [RUN_W-1:0]  RUN_MAX     = 4'd15;
    localparam logic [PEND_W-1:0] PENDING_MAX = 2'd3;
    localparam logic [POS_W-1:0]  DC_POS      = 6'd0;
    localparam logic [POS_W-1:0]  LAST_POS    = 6'd63;
    localparam logic [SYM_W-1:0]  SYM_ZRL     = 8'hF0;
    localparam logic [SYM_W-1:0]  SYM_EOB     = 8'h00;

    typedef enum logic [1:0] {
        K_DC,
        K_AC,
        K_ZRL,
        K_EOB
    } t_kind;

    // One queued job: optional leading ZRLs plus one main symbol.
    typedef struct packed {
        t_kind                    kind;
        logic [PEND_W-1:0]        n_zrl;
        logic [RUN_W-1:0]         run;
        logic signed [VAL_W-1:0]  value;
    } t_job;

    // Number of significant bits of a magnitude (the JPEG category).
    function automatic logic [SIZE_W-1:0] category(input logic [AMP_W-1:0] mag);
        logic [SIZE_W-1:0] cat;
        cat = '0;
        for (int i = 0; i < AMP_W; i++) begin
            if (mag[i]) begin
                cat = SIZE_W'(i + 1);
            end
        end
        return cat;
    endfunction

endpackage

FILE: rtl/core/crlsc_front.sv
// Front end: accepts coefficients, tracks run and predictor state, and queues coding jobs.
module crlsc_front #(
    parameter int COMPONENTS = crlsc_pkg::COMPONENTS_DEF,
    parameter int COEF_WIDTH = crlsc_pkg::COEF_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    input  logic                              i_full,
    input  logic signed [COEF_WIDTH-1:0]      i_coefficient,
    input  logic [crlsc_pkg::POS_W-1:0]       i_position,
    input  logic [crlsc_pkg::COMP_W-1:0]      i_component,
    input  logic                              i_new_scan,
    output logic                              o_job_push,
    output crlsc_pkg::t_job                   o_job
);
    import crlsc_pkg::*;

    localparam int DW  = (COEF_WIDTH > 11 ? COEF_WIDTH : 11) + 1;
    localparam int CIW = (COMPONENTS > 1) ? $clog2(COMPONENTS) : 1;
    localparam logic signed [DW-1:0] AMP_HI  = DW'(AMP_LIMIT);
    localparam logic signed [DW-1:0] AMP_LO  = DW'(-AMP_LIMIT);
    localparam logic signed [DW-1:0] PRED_HI = DW'(PRED_MAX);
    localparam logic signed [DW-1:0] PRED_LO = DW'(PRED_MIN);

    logic signed [AMP_W-1:0] r_pred [COMPONENTS];
    logic signed [AMP_W-1:0] n_pred [COMPONENTS];
    logic [RUN_W-1:0]        r_zero_run, n_zero_run;
    logic [PEND_W-1:0]       r_pending, n_pending;

    logic                    accept;
    logic                    comp_ok;
    logic                    is_dc_pos;
    logic                    is_zero;
    logic signed [AMP_W-1:0] pred;
    logic signed [DW-1:0]    coef_x;
    logic signed [DW-1:0]    pred_x;
    logic signed [DW-1:0]    diff;
    logic signed [DW-1:0]    sel;
    logic signed [VAL_W-1:0] val_clamped;
    logic signed [AMP_W-1:0] pred_store;

    assign accept    = i_push && !i_full;
    assign comp_ok   = 3'(i_component) < 3'(COMPONENTS);
    assign is_dc_pos = (i_position == DC_POS);
    assign is_zero   = (i_coefficient == '0);

    assign pred   = (i_new_scan || !comp_ok) ? '0 : r_pred[i_component[CIW-1:0]];
    assign coef_x = DW'(i_coefficient);
    assign pred_x = DW'(pred);
    assign diff   = coef_x - pred_x;
    assign sel    = is_dc_pos ? diff : coef_x;

    always_comb begin
        if (sel > AMP_HI) begin
            val_clamped = VAL_W'(AMP_HI);
        end else if (sel < AMP_LO) begin
            val_clamped = VAL_W'(AMP_LO);
        end else begin
            val_clamped = VAL_W'(sel);
        end
    end

    always_comb begin
        if (coef_x > PRED_HI) begin
            pred_store = AMP_W'(PRED_HI);
        end else if (coef_x < PRED_LO) begin
            pred_store = AMP_W'(PRED_LO);
        end else begin
            pred_store = AMP_W'(coef_x);
        end
    end

    always_comb begin
        for (int i = 0; i < COMPONENTS; i++) begin
            n_pred[i] = r_pred[i];
            if (accept && i_new_scan) begin
                n_pred[i] = '0;
            end
            if (accept && is_dc_pos && comp_ok && (CIW'(i) == i_component[CIW-1:0])) begin
                n_pred[i] = pred_store;
            end
        end
    end

    always_comb begin
        n_zero_run  = r_zero_run;
        n_pending   = r_pending;
        o_job_push  = 1'b0;
        o_job.kind  = K_AC;
        o_job.n_zrl = '0;
        o_job.run   = r_zero_run;
        o_job.value = val_clamped;
        if (accept) begin
            if (is_dc_pos) begin
                o_job_push = 1'b1;
                o_job.kind = K_DC;
                n_zero_run = '0;
                n_pending  = '0;
            end else if (is_zero) begin
                if (i_position == LAST_POS) begin
                    // End of block drops any held ZRLs.
                    o_job_push = 1'b1;
                    o_job.kind = K_EOB;
                    n_zero_run = '0;
                    n_pending  = '0;
                end else if (r_zero_run < RUN_MAX) begin
                    n_zero_run = r_zero_run + 1'b1;
                end else begin
                    n_zero_run = '0;
                    if (r_pending < PENDING_MAX) begin
                        n_pending = r_pending + 1'b1;
                    end else begin
                        // Hold space is full, so this ZRL goes out at once.
                        o_job_push = 1'b1;
                        o_job.kind = K_ZRL;
                    end
                end
            end else begin
                o_job_push  = 1'b1;
                o_job.kind  = K_AC;
                o_job.n_zrl = r_pending;
                n_zero_run  = '0;
                n_pending   = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_run <= '0;
            r_pending  <= '0;
            for (int i = 0; i < COMPONENTS; i++) begin
                r_pred[i] <= '0;
            end
        end else begin
            r_zero_run <= n_zero_run;
            r_pending  <= n_pending;
            for (int i = 0; i < COMPONENTS; i++) begin
                r_pred[i] <= n_pred[i];
            end
        end
    end

endmodule

FILE: rtl/core/crlsc_queue.sv
// Short job queue between the front end and the symbol emitter.
module crlsc_queue #(
    parameter int DEPTH = crlsc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  crlsc_pkg::t_job i_data,
    output logic            o_full,
    input  logic            i_pop,
    output crlsc_pkg::t_job o_data,
    output logic            o_empty
);
    import crlsc_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_count, n_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == LAST_SLOT) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == LAST_SLOT) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

FILE: rtl/core/crlsc_back.sv
// Back end: expands queued jobs into ZRL and coded symbol words in an output register.
module crlsc_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  crlsc_pkg::t_job                   i_job,
    input  logic                              i_job_valid,
    output logic                              o_job_pop,
    output logic                              o_empty,
    input  logic                              i_pop,
    output logic                              o_is_dc,
    output logic [crlsc_pkg::SYM_W-1:0]       o_symbol,
    output logic [crlsc_pkg::AMP_W-1:0]       o_amplitude_bits,
    output logic [crlsc_pkg::SIZE_W-1:0]      o_amplitude_size,
    output logic                              o_last
);
    import crlsc_pkg::*;

    logic                r_valid, n_valid;
    logic [PEND_W-1:0]   r_zrl_idx, n_zrl_idx;
    logic                r_is_dc;
    logic [SYM_W-1:0]    r_symbol;
    logic [AMP_W-1:0]    r_amp;
    logic [SIZE_W-1:0]   r_size;
    logic                r_last;

    logic                slot_free;
    logic                take;
    logic                emit_zrl;
    logic                neg;
    logic [AMP_W-1:0]    mag;
    logic [SIZE_W-1:0]   size;
    logic [AMP_W-1:0]    mask;
    logic [VAL_W-1:0]    val_m1;
    logic [AMP_W-1:0]    amp;
    logic                m_is_dc;
    logic [SYM_W-1:0]    m_symbol;
    logic [AMP_W-1:0]    m_amp;
    logic [SIZE_W-1:0]   m_size;

    assign slot_free = !r_valid || i_pop;
    assign take      = slot_free && i_job_valid;
    assign emit_zrl  = (r_zrl_idx < i_job.n_zrl);
    assign o_job_pop = take && !emit_zrl;

    // Negative values send the low size bits of value minus one.
    assign neg    = i_job.value[VAL_W-1];
    assign mag    = neg ? AMP_W'(-i_job.value) : i_job.value[AMP_W-1:0];
    assign size   = category(mag);
    assign mask   = AMP_W'((VAL_W'(1) << size) - 1'b1);
    assign val_m1 = i_job.value - 1'b1;
    assign amp    = (neg ? val_m1[AMP_W-1:0] : i_job.value[AMP_W-1:0]) & mask;

    always_comb begin
        unique case (i_job.kind)
            K_DC: begin
                m_is_dc  = 1'b1;
                m_symbol = SYM_W'(size);
                m_amp    = amp;
                m_size   = size;
            end
            K_AC: begin
                m_is_dc  = 1'b0;
                m_symbol = {i_job.run, size};
                m_amp    = amp;
                m_size   = size;
            end
            K_ZRL: begin
                m_is_dc  = 1'b0;
                m_symbol = SYM_ZRL;
                m_amp    = '0;
                m_size   = '0;
            end
            K_EOB: begin
                m_is_dc  = 1'b0;
                m_symbol = SYM_EOB;
                m_amp    = '0;
                m_size   = '0;
            end
            default: begin
                m_is_dc  = 1'b0;
                m_symbol = SYM_EOB;
                m_amp    = '0;
                m_size   = '0;
            end
        endcase
    end

    always_comb begin
        n_valid   = r_valid;
        n_zrl_idx = r_zrl_idx;
        if (take) begin
            n_valid   = 1'b1;
            n_zrl_idx = emit_zrl ? r_zrl_idx + 1'b1 : '0;
        end else if (i_pop) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_zrl_idx <= '0;
        end else begin
            r_valid   <= n_valid;
            r_zrl_idx <= n_zrl_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            if (emit_zrl) begin
                r_is_dc  <= 1'b0;
                r_symbol <= SYM_ZRL;
                r_amp    <= '0;
                r_size   <= '0;
                r_last   <= 1'b0;
            end else begin
                r_is_dc  <= m_is_dc;
                r_symbol <= m_symbol;
                r_amp    <= m_amp;
                r_size   <= m_size;
                r_last   <= 1'b1;
            end
        end
    end

    assign o_empty          = !r_valid;
    assign o_is_dc          = r_is_dc;
    assign o_symbol         = r_symbol;
    assign o_amplitude_bits = r_amp;
    assign o_amplitude_size = r_size;
    assign o_last           = r_last;

    a_dc_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_is_dc) |-> r_last)
        else $error("DC word not marked last");

    a_not_last_is_zrl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_last) |-> (r_symbol == SYM_ZRL))
        else $error("non-final word is not a ZRL");

    a_zrl_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_job_valid |-> (r_zrl_idx <= i_job.n_zrl))
        else $error("ZRL counter passed the job's ZRL count");

    a_size_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_size <= SIZE_W'(AMP_W)))
        else $error("amplitude size above eleven");

endmodule

FILE: rtl/core/coefficient_run_length_symbol_coder.sv
// Top level of the coefficient run-length symbol coder.
// Takes one quantized coefficient word per cycle and turns it into DC/AC run-length
// symbols. Each accepted word is classified in the same cycle by the front end, which
// updates the zero run, the held-ZRL count and the DC predictors and writes at most one
// job into a QUEUE_DEPTH-entry queue. The back end expands each job into its held
// ZRL words and then its main word, one result word per cycle from its output register
// while that register is empty or being popped; a nonzero AC coefficient can produce
// up to four words. Input is accepted every cycle while the queue has room, and the
// result side delivers one word per cycle while pop is held high and jobs are waiting.
// A result passes through the queue and then the output register on its way out.
module coefficient_run_length_symbol_coder #(
    parameter int COMPONENTS  = crlsc_pkg::COMPONENTS_DEF,
    parameter int COEF_WIDTH  = crlsc_pkg::COEF_WIDTH_DEF,
    parameter int QUEUE_DEPTH = crlsc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic signed [COEF_WIDTH-1:0]      i_coefficient,
    input  logic [crlsc_pkg::POS_W-1:0]       i_position,
    input  logic [crlsc_pkg::COMP_W-1:0]      i_component,
    input  logic                              i_new_scan,
    output logic                              empty,
    input  logic                              pop,
    output logic                              o_is_dc,
    output logic [crlsc_pkg::SYM_W-1:0]       o_symbol,
    output logic [crlsc_pkg::AMP_W-1:0]       o_amplitude_bits,
    output logic [crlsc_pkg::SIZE_W-1:0]      o_amplitude_size,
    output logic                              o_last
);
    import crlsc_pkg::*;

    t_job job_in;
    t_job job_head;
    logic job_push;
    logic job_pop;
    logic q_empty;

    crlsc_front #(
        .COMPONENTS (COMPONENTS),
        .COEF_WIDTH (COEF_WIDTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_full        (full),
        .i_coefficient (i_coefficient),
        .i_position    (i_position),
        .i_component   (i_component),
        .i_new_scan    (i_new_scan),
        .o_job_push    (job_push),
        .o_job         (job_in)
    );

    crlsc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .o_full  (full),
        .i_pop   (job_pop),
        .o_data  (job_head),
        .o_empty (q_empty)
    );

    crlsc_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_job            (job_head),
        .i_job_valid      (!q_empty),
        .o_job_pop        (job_pop),
        .o_empty          (empty),
        .i_pop            (pop),
        .o_is_dc          (o_is_dc),
        .o_symbol         (o_symbol),
        .o_amplitude_bits (o_amplitude_bits),
        .o_amplitude_size (o_amplitude_size),
        .o_last           (o_last)
    );

endmodule

FILE: tb/symbol_stream_checker.sv
// Checker that predicts the coded symbol words of the run-length coder and compares them.
module symbol_stream_checker
    import crlsc_pkg::*;
(
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    input  logic                                i_full,
    input  logic signed [COEF_WIDTH_DEF-1:0]    i_coefficient,
    input  logic [POS_W-1:0]                    i_position,
    input  logic [COMP_W-1:0]                   i_component,
    input  logic                                i_new_scan,
    input  logic                                i_empty,
    input  logic                                i_pop,
    input  logic                                i_is_dc,
    input  logic [SYM_W-1:0]                    i_symbol,
    input  logic [AMP_W-1:0]                    i_amplitude_bits,
    input  logic [SIZE_W-1:0]                   i_amplitude_size,
    input  logic                                i_last,
    output int                                  o_fail_count,
    output int                                  o_open_words
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic               is_dc;
        logic [SYM_W-1:0]   symbol;
        logic [AMP_W-1:0]   bits;
        logic [SIZE_W-1:0]  size;
        logic               last;
    } t_coded_word;

    t_coded_word        due_words[$];
    logic [RUN_W-1:0]   zero_run;
    logic [PEND_W-1:0]  held_zrl;
    int                 dc_pred[COMPONENTS_DEF];
    int                 mismatch_count = 0;

    assign o_fail_count = mismatch_count;

    function automatic int clamp_int(input int v, input int lo, input int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int category_of(input int v);
        int mag;
        int n;
        mag = (v < 0) ? -v : v;
        n = 0;
        while (mag != 0) begin
            n++;
            mag = mag >> 1;
        end
        return n;
    endfunction

    // Amplitude bits: negatives are sent as value + 2^size - 1.
    function automatic t_coded_word make_word(input logic dc, input logic [SYM_W-1:0] sym,
                                              input int v, input logic last);
        t_coded_word w;
        int size;
        size = category_of(v);
        w.is_dc = dc;
        w.symbol = sym;
        w.size = SIZE_W'(size);
        if (size == 0) begin
            w.bits = '0;
        end else if (v > 0) begin
            w.bits = AMP_W'(v);
        end else begin
            w.bits = AMP_W'(v + (1 << size) - 1);
        end
        w.last = last;
        return w;
    endfunction

    task automatic queue_word(input t_coded_word w);
        due_words.insert(due_words.size(), w);
    endtask

    task automatic code_coefficient(input logic signed [COEF_WIDTH_DEF-1:0] coef,
                                    input logic [POS_W-1:0] pos,
                                    input logic [COMP_W-1:0] comp, input logic scan);
        int value;
        int pred;
        int diff;
        int size;
        if (scan) begin
            for (int k = 0; k < COMPONENTS_DEF; k++) begin
                dc_pred[k] = 0;
            end
        end
        value = coef;
        if (pos == DC_POS) begin
            pred = 0;
            if (comp < COMPONENTS_DEF) begin
                pred = dc_pred[comp];
                dc_pred[comp] = clamp_int(value, PRED_MIN, PRED_MAX);
            end
            diff = clamp_int(value - pred, -AMP_LIMIT, AMP_LIMIT);
            queue_word(make_word(1'b1, SYM_W'(category_of(diff)), diff, 1'b1));
            zero_run = '0;
            held_zrl = '0;
        end else if (value == 0) begin
            if (pos == LAST_POS) begin
                // End of block: held ZRLs are dropped.
                queue_word(make_word(1'b0, SYM_EOB, 0, 1'b1));
                zero_run = '0;
                held_zrl = '0;
            end else if (zero_run < RUN_MAX) begin
                zero_run = zero_run + 1'b1;
            end else begin
                zero_run = '0;
                if (held_zrl < PENDING_MAX) begin
                    held_zrl = held_zrl + 1'b1;
                end else begin
                    queue_word(make_word(1'b0, SYM_ZRL, 0, 1'b1));
                end
            end
        end else begin
            value = clamp_int(value, -AMP_LIMIT, AMP_LIMIT);
            size = category_of(value);
            for (int p = 0; p < held_zrl; p++) begin
                queue_word(make_word(1'b0, SYM_ZRL, 0, 1'b0));
            end
            queue_word(make_word(1'b0, {zero_run, SIZE_W'(size)}, value, 1'b1));
            zero_run = '0;
            held_zrl = '0;
        end
    endtask

    task automatic compare_field(input string field, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_coded_word w;
        if (!i_rst_n) begin
            due_words.delete();
            zero_run = '0;
            held_zrl = '0;
            for (int k = 0; k < COMPONENTS_DEF; k++) begin
                dc_pred[k] = 0;
            end
        end else begin
            // A word cannot leave in the cycle its coefficient enters, so check first.
            if (i_pop && !i_empty) begin
                if (due_words.size() == 0) begin
                    $display("%0t: unexpected word: is_dc %0d symbol %0d bits %0d size %0d",
                             $time, i_is_dc, i_symbol, i_amplitude_bits, i_amplitude_size);
                    mismatch_count++;
                end else begin
                    w = due_words.pop_front();
                    compare_field("is_dc", w.is_dc, i_is_dc);
                    compare_field("symbol", w.symbol, i_symbol);
                    compare_field("amplitude_bits", w.bits, i_amplitude_bits);
                    compare_field("amplitude_size", w.size, i_amplitude_size);
                    compare_field("last", w.last, i_last);
                end
            end
            if (i_push && !i_full) begin
                code_coefficient(i_coefficient, i_position, i_component, i_new_scan);
            end
        end
        o_open_words <= due_words.size();
    end

endmodule

FILE: tb/tb.sv
// Testbench top: drives coefficient words and result pops, and reports the verdict.
module tb;
    import crlsc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = COEF_WIDTH_DEF;
    localparam int CYCLE_LIMIT = 300000;
    localparam int RANDOM_PER_PHASE = 70;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   push = 1'b0;
    logic                   full;
    logic signed [CW-1:0]   i_coefficient = '0;
    logic [POS_W-1:0]       i_position = '0;
    logic [COMP_W-1:0]      i_component = '0;
    logic                   i_new_scan = 1'b0;
    logic                   empty;
    logic                   pop = 1'b0;
    logic                   o_is_dc;
    logic [SYM_W-1:0]       o_symbol;
    logic [AMP_W-1:0]       o_amplitude_bits;
    logic [SIZE_W-1:0]      o_amplitude_size;
    logic                   o_last;

    int fail_count;
    int open_words;
    int sent_count = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int cycle_count = 0;

    coefficient_run_length_symbol_coder u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_coefficient    (i_coefficient),
        .i_position       (i_position),
        .i_component      (i_component),
        .i_new_scan       (i_new_scan),
        .empty            (empty),
        .pop              (pop),
        .o_is_dc          (o_is_dc),
        .o_symbol         (o_symbol),
        .o_amplitude_bits (o_amplitude_bits),
        .o_amplitude_size (o_amplitude_size),
        .o_last           (o_last)
    );

    symbol_stream_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .i_full           (full),
        .i_coefficient    (i_coefficient),
        .i_position       (i_position),
        .i_component      (i_component),
        .i_new_scan       (i_new_scan),
        .i_empty          (empty),
        .i_pop            (pop),
        .i_is_dc          (o_is_dc),
        .i_symbol         (o_symbol),
        .i_amplitude_bits (o_amplitude_bits),
        .i_amplitude_size (o_amplitude_size),
        .i_last           (o_last),
        .o_fail_count     (fail_count),
        .o_open_words     (open_words)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        pop <= i_rst_n && ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_word(input logic signed [CW-1:0] coef, input int pos, input int comp,
                             input logic scan);
        while ($urandom_range(0, 99) < idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_coefficient <= coef;
        i_position <= POS_W'(pos);
        i_component <= COMP_W'(comp);
        i_new_scan <= scan;
        @(posedge i_clk);
        while (full) begin
            @(posedge i_clk);
        end
        sent_count++;
    endtask

    // Holds the input low until every predicted word has been popped.
    task automatic wait_drained();
        push <= 1'b0;
        @(posedge i_clk);
        while (open_words != 0) begin
            @(posedge i_clk);
        end
    endtask

    function automatic logic signed [CW-1:0] pick_coef();
        int v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: v = $urandom_range(1, 15);
            5, 6, 7: return CW'($urandom);
            8: begin
                case ($urandom_range(0, 2))
                    0: v = 1023;
                    1: v = -1024;
                    default: v = -1;
                endcase
                return CW'(v);
            end
            default: v = $urandom_range(16, 511);
        endcase
        if ($urandom_range(0, 1)) begin
            v = -v;
        end
        return CW'(v);
    endfunction

    function automatic logic signed [CW-1:0] pick_nonzero();
        logic signed [CW-1:0] v;
        v = pick_coef();
        while (v == 0) begin
            v = pick_coef();
        end
        return v;
    endfunction

    task automatic send_block();
        int comp;
        int pos;
        int run_len;
        int r;
        logic scan;
        r = $urandom_range(0, 15);
        comp = (r < 2) ? 3 : r % 3;
        scan = ($urandom_range(0, 19) == 0);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
                send_word(pick_coef(), DC_POS, comp, scan);
                pos = 1;
                repeat ($urandom_range(0, 8)) begin
                    send_word($urandom_range(0, 1) ? CW'(0) : pick_nonzero(), pos, comp, 1'b0);
                    pos = (pos + $urandom_range(1, 6) > 62) ? 62 : pos + $urandom_range(1, 6);
                end
                r = $urandom_range(0, 9);
                // Some blocks are left open and get cut off by the next DC word.
                if (r < 7) begin
                    send_word('0, LAST_POS, comp, 1'b0);
                end else if (r < 9) begin
                    send_word(pick_nonzero(), LAST_POS, comp, 1'b0);
                end
            end
            5, 6, 7: begin
                case ($urandom_range(0, 7))
                    0: run_len = 15;
                    1: run_len = 16;
                    2: run_len = 32;
                    3: run_len = 48;
                    4: run_len = 63;
                    5: run_len = 64;
                    6: run_len = $urandom_range(65, 70);
                    default: run_len = $urandom_range(0, 70);
                endcase
                send_word(pick_coef(), DC_POS, comp, scan);
                for (int i = 0; i < run_len; i++) begin
                    send_word('0, 1 + i % 62, comp, 1'b0);
                end
                r = $urandom_range(0, 3);
                if (r < 2) begin
                    send_word(pick_nonzero(), $urandom_range(1, 62), comp, 1'b0);
                end else if (r == 2) begin
                    send_word('0, LAST_POS, comp, 1'b0);
                end else begin
                    send_word(pick_nonzero(), LAST_POS, comp, 1'b0);
                end
            end
            default: begin
                repeat ($urandom_range(1, 4)) begin
                    send_word(CW'($urandom), $urandom_range(0, 63), $urandom_range(0, 3),
                              ($urandom_range(0, 7) == 0));
                end
            end
        endcase
    endtask

    initial begin
        int target;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // DC extremes, the unused component, and a fresh scan.
        send_word(CW'(1023), DC_POS, 0, 1'b1);
        send_word(CW'(-1024), DC_POS, 0, 1'b0);
        send_word(CW'(-1024), DC_POS, 1, 1'b0);
        send_word(CW'(0), DC_POS, 2, 1'b0);
        send_word(CW'(7), DC_POS, 3, 1'b0);
        // AC extremes and a short zero run.
        send_word(CW'(1023), 1, 0, 1'b0);
        send_word(CW'(-1024), 2, 0, 1'b0);
        send_word(CW'(-1), 3, 0, 1'b0);
        send_word('0, 4, 0, 1'b0);
        send_word('0, 5, 0, 1'b0);
        send_word(CW'(1), 6, 0, 1'b0);
        // A scan reset on an AC word, then an end of block over a pending run.
        send_word('0, 62, 0, 1'b1);
        send_word('0, LAST_POS, 0, 1'b0);
        send_word(CW'(1), DC_POS, 0, 1'b0);
        // A DC word in the middle of a block drops the open run.
        send_word('0, 10, 1, 1'b0);
        send_word('0, 11, 1, 1'b0);
        send_word(CW'(5), DC_POS, 1, 1'b0);
        send_word(CW'(3), 1, 1, 1'b0);
        // Nonzero last coefficient gives no end of block; a zero one right after does.
        send_word(CW'(-5), LAST_POS, 1, 1'b0);
        send_word('0, LAST_POS, 1, 1'b0);
        wait_drained();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct <= 0;  end
                1: begin idle_pct = 50; stall_pct <= 0;  end
                2: begin idle_pct = 0;  stall_pct <= 50; end
                default: begin idle_pct = 10; stall_pct <= 10; end
            endcase
            target = sent_count + RANDOM_PER_PHASE;
            while (sent_count < target) begin
                send_block();
            end
            wait_drained();
        end

        // Room for any stray word still in the pipeline.
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && open_words == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
